>>> rtl/rtaa_pkg.sv
// Shared types, codes and constants for the RGB565 to text attribute unit.
// No dependencies; every other file in rtl imports this package.
package rtaa_pkg;

    localparam int unsigned ChanW  = 8;
    localparam int unsigned LevelW = 3;

    typedef struct packed {
        logic [7:0]  entry_index;
        logic [15:0] palette_word;
    } item_t;

    typedef struct packed {
        logic [7:0] result_index;
        logic [3:0] text_pair;
        logic       bold_flag;
        logic [6:0] fill_char;
    } result_t;

    typedef enum logic [3:0] {
        HUE_BLACK,
        HUE_RED,
        HUE_GREEN,
        HUE_BLUE,
        HUE_YELLOW,
        HUE_BROWN,
        HUE_MAGENTA,
        HUE_CYAN,
        HUE_WHITE,
        HUE_OTHER
    } hue_t;

    localparam logic [6:0] CH_SPACE = 7'h20;
    localparam logic [6:0] CH_DOT   = 7'h2E;
    localparam logic [6:0] CH_PLUS  = 7'h2B;
    localparam logic [6:0] CH_PCT   = 7'h25;
    localparam logic [6:0] CH_AT    = 7'h40;
    localparam logic [6:0] CH_DOLLAR = 7'h24;
    localparam logic [6:0] CH_HASH  = 7'h23;

    // Expanded channels, per-channel low flags and the channel-pair relations they imply.
    typedef struct packed {
        logic [7:0]        entry_index;
        logic [ChanW-1:0]  r;
        logic [ChanW-1:0]  g;
        logic [ChanW-1:0]  b;
        logic              r_lt85;
        logic              g_lt85;
        logic              b_lt85;
        logic              rg_lt32;
        logic              rg_lt48;
        logic              rg_lt100;
        logic              rb_lt48;
        logic              rb_lt64;
        logic              gb_lt48;
        logic              gb_lt64;
        logic              rb_gt64;
        logic              rg_gt64;
        logic              br_gt64;
    } cmp_t;

    // Chosen hue, brightness level within it, and fallback attributes.
    typedef struct packed {
        logic [7:0]        entry_index;
        hue_t              hue;
        logic [LevelW-1:0] level;
        logic [2:0]        fb_pair;
        logic              fb_bold;
    } cls_t;

endpackage

>>> rtl/rgb565_to_text_attribute_unit.sv
// Top level of the RGB565 to text attribute unit: three-stage pipeline.
// Depends on rtaa_pkg, rtaa_compare, rtaa_classify and rtaa_encode.
//
// Each transaction is one palette word with its entry number, taken at a clock
// edge where start is high. The unit takes one transaction every clock and
// busy stays low; the result is on result with done high for one cycle, in the
// order the words came in, after passing the three register stages (channel
// compare, hue select, attribute encode). There is no output buffering: the
// receiver must take each result in the cycle that done marks it.
module rgb565_to_text_attribute_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  rtaa_pkg::item_t   item,
    output logic              done,
    output rtaa_pkg::result_t result
);
    import rtaa_pkg::*;

    logic  accept;
    logic  cmp_valid;
    cmp_t  cmp;
    logic  cls_valid;
    cls_t  cls;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    rtaa_compare u_compare (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .item      (item),
        .out_valid (cmp_valid),
        .stage     (cmp)
    );

    rtaa_classify u_classify (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmp_valid),
        .cmp       (cmp),
        .out_valid (cls_valid),
        .stage     (cls)
    );

    rtaa_encode u_encode (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cls_valid),
        .cls       (cls),
        .out_valid (done),
        .result    (result)
    );

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##3 done)
        else $error("accepted transaction did not complete in three cycles");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 3))
        else $error("result without a matching transaction");

    a_index_echo: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.result_index == $past(item.entry_index, 3))
        else $error("result index does not match its transaction");

    a_bold_char: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.bold_flag |-> result.fill_char != CH_SPACE
                                  && result.fill_char != CH_DOT)
        else $error("bold result with blank fill character");

endmodule

>>> rtl/rtaa_compare.sv
// Stage one: expand RGB565 to 8-bit channels and register pairwise relations.
// Depends on rtaa_pkg.
module rtaa_compare (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  rtaa_pkg::item_t  item,
    output logic             out_valid,
    output rtaa_pkg::cmp_t   stage
);
    import rtaa_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    cmp_t              stage_reg;
    cmp_t              stage_next;
    logic [ChanW-1:0]  r;
    logic [ChanW-1:0]  g;
    logic [ChanW-1:0]  b;
    logic signed [8:0] d_rg;
    logic signed [8:0] d_rb;
    logic signed [8:0] d_gb;

    always_comb
    begin
        r = {item.palette_word[15:11], 3'b000};
        g = {item.palette_word[10:5], 2'b00};
        b = {item.palette_word[4:0], 3'b000};
        d_rg = $signed({1'b0, r}) - $signed({1'b0, g});
        d_rb = $signed({1'b0, r}) - $signed({1'b0, b});
        d_gb = $signed({1'b0, g}) - $signed({1'b0, b});

        stage_next.entry_index = item.entry_index;
        stage_next.r        = r;
        stage_next.g        = g;
        stage_next.b        = b;
        stage_next.r_lt85   = r < 8'd85;
        stage_next.g_lt85   = g < 8'd85;
        stage_next.b_lt85   = b < 8'd85;
        stage_next.rg_lt32  = (d_rg < 9'sd32) && (d_rg > -9'sd32);
        stage_next.rg_lt48  = (d_rg < 9'sd48) && (d_rg > -9'sd48);
        stage_next.rg_lt100 = (d_rg < 9'sd100) && (d_rg > -9'sd100);
        stage_next.rb_lt48  = (d_rb < 9'sd48) && (d_rb > -9'sd48);
        stage_next.rb_lt64  = (d_rb < 9'sd64) && (d_rb > -9'sd64);
        stage_next.gb_lt48  = (d_gb < 9'sd48) && (d_gb > -9'sd48);
        stage_next.gb_lt64  = (d_gb < 9'sd64) && (d_gb > -9'sd64);
        stage_next.rb_gt64  = d_rb > 9'sd64;
        stage_next.rg_gt64  = d_rg > 9'sd64;
        stage_next.br_gt64  = d_rb < -9'sd64;
        valid_next = in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            stage_reg <= stage_next;
        end
    end

    assign out_valid = valid_reg;
    assign stage     = stage_reg;

endmodule

>>> rtl/rtaa_classify.sv
// Stage two: pick the first matching hue and the brightness level within it.
// Depends on rtaa_pkg.
module rtaa_classify (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  rtaa_pkg::cmp_t  cmp,
    output logic            out_valid,
    output rtaa_pkg::cls_t  stage
);
    import rtaa_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    cls_t  stage_reg;
    cls_t  stage_next;
    hue_t  hue;

    always_comb
    begin
        if (cmp.r_lt85 && cmp.g_lt85 && cmp.b_lt85)
            hue = HUE_BLACK;
        else if (cmp.g_lt85 && cmp.b_lt85)
            hue = HUE_RED;
        else if (cmp.r_lt85 && cmp.b_lt85)
            hue = HUE_GREEN;
        else if (cmp.r_lt85 && cmp.g_lt85)
            hue = HUE_BLUE;
        else if (cmp.rg_lt32 && cmp.rb_gt64)
            hue = HUE_YELLOW;
        else if (cmp.rg_lt100 && cmp.rb_gt64)
            hue = HUE_BROWN;
        else if (cmp.rb_lt64 && cmp.rg_gt64)
            hue = HUE_MAGENTA;
        else if (cmp.gb_lt64 && cmp.br_gt64)
            hue = HUE_CYAN;
        else if (cmp.rg_lt48 && cmp.rb_lt48 && cmp.gb_lt48)
            hue = HUE_WHITE;
        else
            hue = HUE_OTHER;

        stage_next.entry_index = cmp.entry_index;
        stage_next.hue         = hue;
        stage_next.fb_pair     = {cmp.r > 8'd64, cmp.g > 8'd64, cmp.b > 8'd64};
        stage_next.fb_bold     = (cmp.r > 8'd128) || (cmp.g > 8'd128) || (cmp.b > 8'd128);

        // Count thresholds passed on the deciding channel.
        unique case (hue)
            HUE_BLACK:
                stage_next.level = LevelW'(cmp.r >= 8'd64);
            HUE_RED:
                stage_next.level = LevelW'(cmp.r >= 8'd120) + LevelW'(cmp.r >= 8'd160)
                                 + LevelW'(cmp.r >= 8'd200);
            HUE_GREEN:
                stage_next.level = LevelW'(cmp.g >= 8'd120) + LevelW'(cmp.g >= 8'd160)
                                 + LevelW'(cmp.g >= 8'd200);
            HUE_BLUE:
                stage_next.level = LevelW'(cmp.b >= 8'd120) + LevelW'(cmp.b >= 8'd160)
                                 + LevelW'(cmp.b >= 8'd192);
            HUE_YELLOW:
                stage_next.level = LevelW'(cmp.r >= 8'd64) + LevelW'(cmp.r >= 8'd128)
                                 + LevelW'(cmp.r >= 8'd200);
            HUE_BROWN:
                stage_next.level = LevelW'(cmp.r >= 8'd100) + LevelW'(cmp.r >= 8'd192)
                                 + LevelW'(cmp.r >= 8'd220);
            HUE_MAGENTA:
                stage_next.level = LevelW'(cmp.r >= 8'd64) + LevelW'(cmp.r >= 8'd128);
            HUE_CYAN:
                stage_next.level = LevelW'(cmp.b >= 8'd64) + LevelW'(cmp.b >= 8'd128);
            HUE_WHITE:
                stage_next.level = LevelW'(cmp.r >= 8'd92) + LevelW'(cmp.r >= 8'd120)
                                 + LevelW'(cmp.r >= 8'd150) + LevelW'(cmp.r >= 8'd200);
            default:
                stage_next.level = '0;
        endcase
        valid_next = in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            stage_reg <= stage_next;
        end
    end

    assign out_valid = valid_reg;
    assign stage     = stage_reg;

endmodule

>>> rtl/rtaa_encode.sv
// Stage three: map hue and level to color pair, bold flag and fill character.
// Depends on rtaa_pkg.
module rtaa_encode (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  rtaa_pkg::cls_t    cls,
    output logic              out_valid,
    output rtaa_pkg::result_t result
);
    import rtaa_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    result_t  result_reg;
    result_t  result_next;
    logic [3:0] pair;
    logic       bold;
    logic [6:0] fill;

    always_comb
    begin
        pair = 4'd0;
        bold = 1'b0;
        fill = CH_SPACE;
        unique case (cls.hue) inside
            HUE_BLACK:
            begin
                if (cls.level != '0)
                begin
                    pair = 4'd8;
                    fill = CH_DOT;
                end
            end
            HUE_RED, HUE_GREEN, HUE_BLUE:
            begin
                pair = (cls.hue == HUE_RED) ? 4'd4 : (cls.hue == HUE_GREEN) ? 4'd2 : 4'd1;
                case (cls.level)
                    3'd0:    fill = CH_PLUS;
                    3'd1:    begin bold = 1'b1; fill = CH_PCT; end
                    3'd2:    begin bold = 1'b1; fill = CH_AT; end
                    default: pair = pair | 4'd8;
                endcase
            end
            HUE_YELLOW, HUE_BROWN:
            begin
                pair = 4'd6;
                case (cls.level)
                    3'd0:    fill = CH_PLUS;
                    3'd1:    pair = 4'd14;
                    3'd2:    begin bold = 1'b1; fill = CH_DOLLAR; end
                    default: begin bold = 1'b1; fill = CH_AT; end
                endcase
            end
            HUE_MAGENTA, HUE_CYAN:
            begin
                pair = (cls.hue == HUE_MAGENTA) ? 4'd4 : 4'd3;
                case (cls.level)
                    3'd0:    fill = CH_PLUS;
                    3'd1:    begin bold = 1'b1; fill = CH_AT; end
                    default: pair = (cls.hue == HUE_MAGENTA) ? 4'd13 : 4'd11;
                endcase
            end
            HUE_WHITE:
            begin
                case (cls.level)
                    3'd0:    begin bold = 1'b1; fill = CH_PLUS; end
                    3'd1:    begin bold = 1'b1; fill = CH_DOLLAR; end
                    3'd2:    begin pair = 4'd7; fill = CH_PLUS; end
                    3'd3:    begin pair = 4'd7; bold = 1'b1; fill = CH_AT; end
                    default: pair = 4'd15;
                endcase
            end
            default:
            begin
                pair = {1'b0, cls.fb_pair};
                bold = cls.fb_bold;
                fill = CH_HASH;
            end
        endcase
        result_next.result_index = cls.entry_index;
        result_next.text_pair    = pair;
        result_next.bold_flag    = bold;
        result_next.fill_char    = fill;
        valid_next = in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = valid_reg;
    assign result    = result_reg;

endmodule

>>> bench/rgb565_to_text_attribute_unit_tb.sv
// Testbench for rgb565_to_text_attribute_unit: drives palette words, predicts each attribute
// and checks every result in order. Depends on rtaa_pkg and the unit itself.
`timescale 1ns / 1ps

module rgb565_to_text_attribute_unit_tb;

    import rtaa_pkg::*;

    localparam int unsigned Latency    = 3;
    localparam int unsigned RandWords  = 650;
    localparam int unsigned CycleLimit = 200000;

    typedef struct {
        item_t word_item;
        bit    drain;
    } pending_t;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    item_t   cmd_item;
    logic    done;
    result_t attr_result;

    pending_t palette_q[$];
    result_t  attr_expect_q[$];

    int unsigned cycle_cnt;
    int unsigned words_taken;
    int unsigned results_seen;
    int unsigned fallback_cnt;
    int unsigned bold_cnt;
    int unsigned error_cnt;
    int unsigned burst_left;
    int unsigned gap_left;

    rgb565_to_text_attribute_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (cmd_item),
        .done   (done),
        .result (attr_result)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic int chan_dist(int a, int b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic result_t pack_attr(logic [7:0] idx, logic [3:0] pair, logic bold,
                                          logic [6:0] ch);
        result_t res;
        res.result_index = idx;
        res.text_pair    = pair;
        res.bold_flag    = bold;
        res.fill_char    = ch;
        return res;
    endfunction

    function automatic result_t attr_of(item_t it);
        int         r;
        int         g;
        int         b;
        logic [7:0] idx;
        logic [3:0] pair;
        result_t    res;
        idx = it.entry_index;
        r = int'(it.palette_word[15:11]) * 8;
        g = int'(it.palette_word[10:5]) * 4;
        b = int'(it.palette_word[4:0]) * 8;
        if (r < 85 && g < 85 && b < 85)
        begin
            if (r < 64) res = pack_attr(idx, 4'd0, 1'b0, CH_SPACE);
            else        res = pack_attr(idx, 4'd8, 1'b0, CH_DOT);
        end
        else if (g < 85 && b < 85)
        begin
            if (r < 120)      res = pack_attr(idx, 4'd4, 1'b0, CH_PLUS);
            else if (r < 160) res = pack_attr(idx, 4'd4, 1'b1, CH_PCT);
            else if (r < 200) res = pack_attr(idx, 4'd4, 1'b1, CH_AT);
            else              res = pack_attr(idx, 4'd12, 1'b0, CH_SPACE);
        end
        else if (r < 85 && b < 85)
        begin
            if (g < 120)      res = pack_attr(idx, 4'd2, 1'b0, CH_PLUS);
            else if (g < 160) res = pack_attr(idx, 4'd2, 1'b1, CH_PCT);
            else if (g < 200) res = pack_attr(idx, 4'd2, 1'b1, CH_AT);
            else              res = pack_attr(idx, 4'd10, 1'b0, CH_SPACE);
        end
        else if (r < 85 && g < 85)
        begin
            if (b < 120)      res = pack_attr(idx, 4'd1, 1'b0, CH_PLUS);
            else if (b < 160) res = pack_attr(idx, 4'd1, 1'b1, CH_PCT);
            else if (b < 192) res = pack_attr(idx, 4'd1, 1'b1, CH_AT);
            else              res = pack_attr(idx, 4'd9, 1'b0, CH_SPACE);
        end
        else if (chan_dist(r, g) < 32 && (r - b) > 64)
        begin
            if (r < 64)       res = pack_attr(idx, 4'd6, 1'b0, CH_PLUS);
            else if (r < 128) res = pack_attr(idx, 4'd14, 1'b0, CH_SPACE);
            else if (r < 200) res = pack_attr(idx, 4'd6, 1'b1, CH_DOLLAR);
            else              res = pack_attr(idx, 4'd6, 1'b1, CH_AT);
        end
        else if (chan_dist(r, g) < 100 && (r - b) > 64)
        begin
            if (r < 100)      res = pack_attr(idx, 4'd6, 1'b0, CH_PLUS);
            else if (r < 192) res = pack_attr(idx, 4'd14, 1'b0, CH_SPACE);
            else if (r < 220) res = pack_attr(idx, 4'd6, 1'b1, CH_DOLLAR);
            else              res = pack_attr(idx, 4'd6, 1'b1, CH_AT);
        end
        else if (chan_dist(r, b) < 64 && (r - g) > 64)
        begin
            if (r < 64)       res = pack_attr(idx, 4'd4, 1'b0, CH_PLUS);
            else if (r < 128) res = pack_attr(idx, 4'd4, 1'b1, CH_AT);
            else              res = pack_attr(idx, 4'd13, 1'b0, CH_SPACE);
        end
        else if (chan_dist(g, b) < 64 && (b - r) > 64)
        begin
            if (b < 64)       res = pack_attr(idx, 4'd3, 1'b0, CH_PLUS);
            else if (b < 128) res = pack_attr(idx, 4'd3, 1'b1, CH_AT);
            else              res = pack_attr(idx, 4'd11, 1'b0, CH_SPACE);
        end
        else if (chan_dist(r, g) < 48 && chan_dist(r, b) < 48 && chan_dist(b, g) < 48)
        begin
            if (r < 92)       res = pack_attr(idx, 4'd0, 1'b1, CH_PLUS);
            else if (r < 120) res = pack_attr(idx, 4'd0, 1'b1, CH_DOLLAR);
            else if (r < 150) res = pack_attr(idx, 4'd7, 1'b0, CH_PLUS);
            else if (r < 200) res = pack_attr(idx, 4'd7, 1'b1, CH_AT);
            else              res = pack_attr(idx, 4'd15, 1'b0, CH_SPACE);
        end
        else
        begin
            pair = {1'b0, r > 64, g > 64, b > 64};
            res = pack_attr(idx, pair, r > 128 || g > 128 || b > 128, CH_HASH);
        end
        return res;
    endfunction

    function automatic logic [15:0] rgb_word(int r, int g, int b);
        int rc;
        int gc;
        int bc;
        rc = (r < 0) ? 0 : (r > 255) ? 255 : r;
        gc = (g < 0) ? 0 : (g > 255) ? 255 : g;
        bc = (b < 0) ? 0 : (b > 255) ? 255 : b;
        return {rc[7:3], gc[7:2], bc[7:3]};
    endfunction

    task automatic queue_word(logic [7:0] idx, logic [15:0] w, bit drain);
        pending_t p;
        p.word_item.entry_index  = idx;
        p.word_item.palette_word = w;
        p.drain                  = drain;
        palette_q.push_back(p);
    endtask

    // Sender: bursts of random length, mostly separated by random gaps.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (palette_q.size() == 0)
                start <= 1'b0;
            else if (palette_q[0].drain && attr_expect_q.size() != 0)
                start <= 1'b0;
            else if (gap_left > 0)
            begin
                start <= 1'b0;
                gap_left = gap_left - 1;
            end
            else
            begin
                start    <= 1'b1;
                cmd_item <= palette_q[0].word_item;
                if (burst_left > 0)
                    burst_left = burst_left - 1;
                else
                begin
                    burst_left = $urandom_range(0, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                end
            end
        end
    end

    // Accept transactions, predict, and check results in order.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                results_seen = results_seen + 1;
                if (attr_expect_q.size() == 0)
                begin
                    $display("%0t ns: unexpected result %h, nothing pending", $time, attr_result);
                    error_cnt = error_cnt + 1;
                end
                else
                begin
                    want = attr_expect_q.pop_front();
                    if (attr_result.result_index !== want.result_index)
                    begin
                        $display("%0t ns: result_index expected %0d, got %0d",
                                 $time, want.result_index, attr_result.result_index);
                        error_cnt = error_cnt + 1;
                    end
                    if (attr_result.text_pair !== want.text_pair)
                    begin
                        $display("%0t ns: entry %0d text_pair expected %0d, got %0d", $time,
                                 want.result_index, want.text_pair, attr_result.text_pair);
                        error_cnt = error_cnt + 1;
                    end
                    if (attr_result.bold_flag !== want.bold_flag)
                    begin
                        $display("%0t ns: entry %0d bold_flag expected %0b, got %0b", $time,
                                 want.result_index, want.bold_flag, attr_result.bold_flag);
                        error_cnt = error_cnt + 1;
                    end
                    if (attr_result.fill_char !== want.fill_char)
                    begin
                        $display("%0t ns: entry %0d fill_char expected %h, got %h", $time,
                                 want.result_index, want.fill_char, attr_result.fill_char);
                        error_cnt = error_cnt + 1;
                    end
                end
            end
            if (start && !busy)
            begin
                want = attr_of(cmd_item);
                attr_expect_q.push_back(want);
                void'(palette_q.pop_front());
                words_taken = words_taken + 1;
                if (want.fill_char == CH_HASH)
                    fallback_cnt = fallback_cnt + 1;
                if (want.bold_flag)
                    bold_cnt = bold_cnt + 1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt = cycle_cnt + 1;
        if (cycle_cnt > CycleLimit)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, attr_expect_q.size());
            $display("rgb565_to_text_attribute_unit_tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        int   n;
        int   style;
        int   base;
        int   ch_a;
        int   ch_b;
        int   ch_c;
        int   rot;
        logic [15:0] w;

        rst_n       = 1'b0;
        start       = 1'b0;
        cmd_item    = '0;
        cycle_cnt   = 0;
        words_taken = 0;
        results_seen = 0;
        fallback_cnt = 0;
        bold_cnt    = 0;
        error_cnt   = 0;
        burst_left  = 0;
        gap_left    = 0;

        // Hue cascade corners, brightness bands and the fallback path.
        queue_word(8'd0,   16'h0000, 1'b0);
        queue_word(8'd255, 16'hFFFF, 1'b0);
        queue_word(8'd1,   rgb_word(64, 0, 0), 1'b0);
        queue_word(8'd2,   rgb_word(112, 0, 0), 1'b0);
        queue_word(8'd3,   rgb_word(152, 0, 0), 1'b0);
        queue_word(8'd4,   rgb_word(192, 0, 0), 1'b0);
        queue_word(8'd5,   rgb_word(248, 0, 0), 1'b0);
        queue_word(8'd6,   rgb_word(0, 156, 0), 1'b0);
        queue_word(8'd7,   rgb_word(0, 252, 0), 1'b0);
        queue_word(8'd8,   rgb_word(0, 0, 184), 1'b0);
        queue_word(8'd9,   rgb_word(0, 0, 248), 1'b0);
        queue_word(8'd10,  rgb_word(120, 120, 0), 1'b0);
        queue_word(8'd11,  rgb_word(248, 252, 0), 1'b0);
        queue_word(8'd12,  rgb_word(96, 128, 0), 1'b0);
        queue_word(8'd13,  rgb_word(200, 128, 0), 1'b0);
        queue_word(8'd14,  rgb_word(112, 0, 112), 1'b0);
        queue_word(8'd15,  rgb_word(200, 0, 200), 1'b0);
        queue_word(8'd16,  rgb_word(0, 112, 112), 1'b0);
        queue_word(8'd17,  rgb_word(0, 200, 200), 1'b0);
        queue_word(8'd18,  rgb_word(88, 88, 88), 1'b0);
        queue_word(8'd19,  rgb_word(136, 136, 136), 1'b0);
        queue_word(8'd20,  rgb_word(176, 176, 176), 1'b0);
        queue_word(8'd21,  rgb_word(200, 100, 40), 1'b0);
        queue_word(8'd22,  rgb_word(0, 100, 200), 1'b0);
        queue_word(8'd128, 16'h5555, 1'b0);
        queue_word(8'd127, 16'hAAAA, 1'b0);

        for (n = 0; n < RandWords; n++)
        begin
            style = $urandom_range(0, 3);
            base  = $urandom_range(0, 255);
            case (style)
                0: w = 16'($urandom());
                1: w = rgb_word(($urandom_range(0, 1) != 0) ? $urandom_range(0, 95)
                                                            : $urandom_range(0, 255),
                                ($urandom_range(0, 1) != 0) ? $urandom_range(0, 95)
                                                            : $urandom_range(0, 255),
                                ($urandom_range(0, 1) != 0) ? $urandom_range(0, 95)
                                                            : $urandom_range(0, 255));
                2: w = rgb_word(base, base + int'($urandom_range(0, 120)) - 60,
                                base + int'($urandom_range(0, 120)) - 60);
                default:
                begin
                    ch_a = base;
                    ch_b = base + int'($urandom_range(0, 80)) - 40;
                    ch_c = base - int'($urandom_range(40, 160));
                    rot  = $urandom_range(0, 2);
                    if (rot == 0)      w = rgb_word(ch_a, ch_b, ch_c);
                    else if (rot == 1) w = rgb_word(ch_c, ch_a, ch_b);
                    else               w = rgb_word(ch_b, ch_c, ch_a);
                end
            endcase
            queue_word(8'($urandom_range(0, 255)), w, n == 0 || n == RandWords / 2);
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (palette_q.size() != 0 || attr_expect_q.size() != 0)
            @(negedge clk);
        repeat (Latency + 3) @(posedge clk);
        @(negedge clk);

        if (attr_expect_q.size() != 0)
        begin
            $display("%0t ns: %0d expected results never arrived", $time, attr_expect_q.size());
            error_cnt = error_cnt + 1;
        end
        $display("palette words sent: %0d, attributes checked: %0d, mismatches: %0d",
                 words_taken, results_seen, error_cnt);
        $display("fallback colors: %0d, bold attributes: %0d", fallback_cnt, bold_cnt);
        if (error_cnt == 0)
            $display("rgb565_to_text_attribute_unit_tb: done, clean");
        else
            $display("rgb565_to_text_attribute_unit_tb: done, errors");
        $finish;
    end

endmodule

>>> filelist.f
rtl/rtaa_pkg.sv
rtl/rtaa_compare.sv
rtl/rtaa_classify.sv
rtl/rtaa_encode.sv
rtl/rgb565_to_text_attribute_unit.sv
bench/rgb565_to_text_attribute_unit_tb.sv
